// ===== design/hcbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg
// Shared types and constants of the HTTP chunked body decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  // Width of a chunk size and of the bytes-left counter.
  localparam int CHUNK_BITS = 32;
  // Longest size line, in characters, before it is an error.
  localparam int MAX_LINE   = 31;
  localparam int LINE_W     = $clog2(MAX_LINE + 1);

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Line terminator characters.
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        eor;
  } result_t;

  // Results produced by one body byte, in order.
  typedef struct packed {
    logic [1:0]  count;
    result_t     first;
    result_t     second;
  } push_t;

endpackage

// ===== design/hcbd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_in_if / hcbd_out_if
// Valid/ready channels for body bytes in and decoded results out.
// ----------------------------------------------------------------------------
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] out_byte;
  logic       end_of_run;

  modport source (output valid, output result_kind, output out_byte,
                  output end_of_run, input ready);
  modport sink   (input valid, input result_kind, input out_byte,
                  input end_of_run, output ready);
endinterface

// ===== design/hcbd_res_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_res_fifo
// Result queue: takes up to two results a cycle, hands out one a beat.
// ----------------------------------------------------------------------------
module hcbd_res_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hcbd_pkg::push_t    push_i,
  output logic               room_o,
  hcbd_out_if.source         out_o
);

  hcbd_pkg::result_t                 mem_q [hcbd_pkg::FIFO_DEPTH];
  logic [hcbd_pkg::PTR_W-1:0]        rd_q, rd_d, wr_q, wr_d;
  logic [hcbd_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic                              pop;
  hcbd_pkg::result_t                 head;

  assign head              = mem_q[rd_q];
  assign out_o.valid       = (cnt_q != '0);
  assign out_o.result_kind = head.kind;
  assign out_o.out_byte    = head.data;
  assign out_o.end_of_run  = head.eor;
  assign pop               = out_o.valid && out_o.ready;

  // Leave space for the worst case of two results from one byte.
  assign room_o = (cnt_q <= hcbd_pkg::CNT_W'(hcbd_pkg::FIFO_DEPTH - 2));

  always_comb begin
    rd_d  = rd_q + hcbd_pkg::PTR_W'(pop);
    wr_d  = wr_q + hcbd_pkg::PTR_W'(push_i.count);
    cnt_d = cnt_q + hcbd_pkg::CNT_W'(push_i.count) - hcbd_pkg::CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      rd_q  <= rd_d;
      wr_q  <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_q + hcbd_pkg::PTR_W'(1)] <= push_i.second;
    end
  end

endmodule

// ===== design/http_chunked_body_decoder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder
// Strips HTTP chunked framing from body bytes, one a cycle while not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one body byte a beat, with last_byte set on the final byte
//   of a body. out_o carries results: payload bytes (kind 0), a body-finished
//   marker (kind 1) or a format error (kind 2); end_of_run flags the last
//   result caused by a given body byte. A byte that causes no result (size
//   line characters, chunk CR LF) produces nothing on out_o.
//   Throughput: one body byte per cycle while in_i.ready is high. The byte
//   is held in an input register, decoded by the framing state machine,
//   and its results pushed into a four-entry result queue, whose head
//   is offered on out_o.
//   A final byte inside chunk data gives two results (byte, then error); the
//   queue hands those out one a beat, so sustained input stays at one byte
//   per cycle when out_o is always ready.
//   Stall: while out_o.ready is low the queue fills; in_i.ready drops once
//   the queue can no longer take two more results and the input register
//   is occupied. No result is lost or repeated.
//   Reset: rst_ni clears the queue and returns the decoder to the start of a
//   size line. Every byte with last_byte set also rearms the decoder for the
//   next body; after a finish or an error, later bytes up to the final one
//   are dropped.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  hcbd_in_if.sink    in_i,
  hcbd_out_if.source out_o
);

  localparam int CB = hcbd_pkg::CHUNK_BITS;
  localparam int LW = hcbd_pkg::LINE_W;

  typedef enum logic [2:0] {
    PH_LINE = 3'd0,
    PH_DATA = 3'd1,
    PH_CR   = 3'd2,
    PH_LF   = 3'd3,
    PH_DONE = 3'd4,
    PH_FAIL = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    HX_WS     = 3'd0,
    HX_SIGN   = 3'd1,
    HX_ZERO   = 3'd2,
    HX_X      = 3'd3,
    HX_DIGITS = 3'd4,
    HX_STOP   = 3'd5
  } hx_e;

  typedef struct packed {
    hx_e          step;
    logic [CB-1:0] value;
    logic         neg;
    logic         ovf;
  } parse_t;

  // Append one hex digit, or flag overflow when the top nibble is in use.
  function automatic parse_t add_digit(parse_t s, logic [3:0] d);
    parse_t r;
    r = s;
    if (s.value[CB-1 -: 4] != 4'd0) begin
      r.ovf = 1'b1;
    end else begin
      r.value = {s.value[CB-5:0], d};
    end
    r.step = HX_DIGITS;
    return r;
  endfunction

  // One step of the base-16 size reader.
  function automatic parse_t parse_char(parse_t s, logic [7:0] c);
    parse_t     r;
    logic       dig_ok;
    logic [3:0] dig;
    logic       sign_path;
    r         = s;
    dig_ok    = (c >= "0" && c <= "9") || (c >= "a" && c <= "f") ||
                (c >= "A" && c <= "F");
    dig       = (c <= "9") ? c[3:0] : (c[3:0] + 4'd9);
    sign_path = 1'b0;
    case (s.step)
      HX_WS: begin
        if (c == " " || (c >= 8'd9 && c <= 8'd13)) begin
          r = s;
        end else if (c == "+" || c == "-") begin
          r.neg  = (c == "-");
          r.step = HX_SIGN;
        end else begin
          sign_path = 1'b1;
        end
      end
      HX_SIGN: sign_path = 1'b1;
      HX_ZERO: begin
        if (c == "x" || c == "X") r.step = HX_X;
        else if (dig_ok)          r = add_digit(s, dig);
        else                      r.step = HX_STOP;
      end
      HX_X, HX_DIGITS: begin
        if (dig_ok) r = add_digit(s, dig);
        else        r.step = HX_STOP;
      end
      default: r = s;
    endcase
    if (sign_path) begin
      if (c == "0")   r.step = HX_ZERO;
      else if (dig_ok) r = add_digit(s, dig);
      else            r.step = HX_STOP;
    end
    return r;
  endfunction

  // Input register.
  logic            in_valid_q;
  logic [7:0]      in_byte_q;
  logic            in_last_q;
  logic            room;
  logic            fire;

  // Framing state.
  phase_e          ph_q, ph_d;
  logic [LW-1:0]   len_q, len_d;
  parse_t          ps_q, ps_d;
  logic            crs_q, crs_d;
  logic [CB-1:0]   left_q, left_d;

  hcbd_pkg::push_t push;

  assign fire       = in_valid_q && room;
  assign in_i.ready = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last_byte;
    end
  end

  always_comb begin
    parse_t      ps_a;
    logic [LW:0] len_next;
    logic        fail;
    ph_d   = ph_q;
    len_d  = len_q;
    ps_d   = ps_q;
    crs_d  = crs_q;
    left_d = left_q;
    fail   = 1'b0;
    ps_a   = ps_q;
    push   = '0;
    push.first.kind  = hcbd_pkg::KIND_BYTE;
    push.second.kind = hcbd_pkg::KIND_BYTE;
    len_next = {1'b0, len_q} + (LW+1)'(1);

    if (fire) begin
      unique case (ph_q)
        PH_LINE: begin
          if (crs_q && in_byte_q == hcbd_pkg::CHAR_LF) begin
            // End of size line: check it and move on.
            if (len_q == '0 || ps_q.ovf || (ps_q.neg && ps_q.value != '0)) begin
              fail = 1'b1;
            end else if (ps_q.value == '0) begin
              push.count      = 2'd1;
              push.first.kind = hcbd_pkg::KIND_DONE;
              ph_d            = PH_DONE;
            end else begin
              left_d = ps_q.value;
              ph_d   = PH_DATA;
            end
          end else if (crs_q) begin
            // Lone CR counts as a line character.
            if (len_next > (LW+1)'(hcbd_pkg::MAX_LINE)) begin
              fail = 1'b1;
            end else begin
              ps_a  = parse_char(ps_q, hcbd_pkg::CHAR_CR);
              ps_d  = ps_a;
              len_d = len_next[LW-1:0];
              if (in_byte_q == hcbd_pkg::CHAR_CR) begin
                crs_d = 1'b1;
              end else begin
                crs_d = 1'b0;
                if (len_next + (LW+1)'(1) > (LW+1)'(hcbd_pkg::MAX_LINE)) begin
                  fail = 1'b1;
                end else begin
                  ps_d  = parse_char(ps_a, in_byte_q);
                  len_d = len_next[LW-1:0] + LW'(1);
                end
              end
            end
          end else if (in_byte_q == hcbd_pkg::CHAR_CR) begin
            crs_d = 1'b1;
          end else if (len_next > (LW+1)'(hcbd_pkg::MAX_LINE)) begin
            fail = 1'b1;
          end else begin
            ps_d  = parse_char(ps_q, in_byte_q);
            len_d = len_next[LW-1:0];
          end
        end
        PH_DATA: begin
          push.count      = 2'd1;
          push.first.kind = hcbd_pkg::KIND_BYTE;
          push.first.data = in_byte_q;
          left_d          = left_q - CB'(1);
          if (left_q == CB'(1)) ph_d = PH_CR;
        end
        PH_CR: begin
          if (in_byte_q == hcbd_pkg::CHAR_CR) ph_d = PH_LF;
          else                                fail = 1'b1;
        end
        PH_LF: begin
          if (in_byte_q != hcbd_pkg::CHAR_LF) begin
            fail = 1'b1;
          end else if (in_last_q) begin
            push.count      = 2'd1;
            push.first.kind = hcbd_pkg::KIND_DONE;
            ph_d            = PH_DONE;
          end else begin
            // Clear the line state for the next size line.
            ph_d          = PH_LINE;
            len_d         = '0;
            ps_d          = '0;
            ps_d.step     = HX_WS;
            crs_d         = 1'b0;
          end
        end
        default: ph_d = ph_q;
      endcase

      // Final byte before the body is complete.
      if (!fail && in_last_q && ph_d != PH_DONE && ph_d != PH_FAIL) begin
        fail = 1'b1;
      end

      if (fail) begin
        ph_d = PH_FAIL;
        if (push.count == 2'd0) begin
          push.count      = 2'd1;
          push.first.kind = hcbd_pkg::KIND_ERR;
        end else begin
          push.count       = 2'd2;
          push.second.kind = hcbd_pkg::KIND_ERR;
        end
      end

      push.first.eor  = (push.count == 2'd1);
      push.second.eor = (push.count == 2'd2);

      // Rearm for the next body.
      if (in_last_q) begin
        ph_d      = PH_LINE;
        len_d     = '0;
        ps_d      = '0;
        ps_d.step = HX_WS;
        crs_d     = 1'b0;
        left_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q      <= PH_LINE;
      len_q     <= '0;
      ps_q      <= '0;
      crs_q     <= 1'b0;
      left_q    <= '0;
    end else begin
      ph_q      <= ph_d;
      len_q     <= len_d;
      ps_q      <= ps_d;
      crs_q     <= crs_d;
      left_q    <= left_d;
    end
  end

  hcbd_res_fifo u_res_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule
